// ===== rtl/keypad_debounce_press_to_hid_assert.svh =====
// assertion macros for the keypad debounce block
`ifndef KEYPAD_DEBOUNCE_PRESS_TO_HID_ASSERT_SVH
`define KEYPAD_DEBOUNCE_PRESS_TO_HID_ASSERT_SVH

`ifndef ASSERT_OFF
`define KDPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KDPH_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define KDPH_ASSERT(lbl, prop, msg)
`define KDPH_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/kdph_pkg.sv =====
`timescale 1ns / 1ps

package kdph_pkg;

  localparam int NUM_KEYS_DEF   = 6;
  localparam int RAW_BITS       = 6;
  localparam int STAMP_W        = 32;
  localparam int DEB_W          = 16;
  localparam int ACTIVE_W       = 3;
  localparam int KEY_ID_W       = 3;
  localparam int KEYCODE_W      = 7;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;

  localparam logic [KEYCODE_W-1:0] KEYCODE_BASE    = 7'h68;
  localparam logic [ACTIVE_W-1:0]  ACTIVE_KEYS_RST = 3'd6;
  localparam logic [DEB_W-1:0]     DEBOUNCE_RST    = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_KEYS = 1'b0,
    CFG_LOCKOUT_MS  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic settled_nxt;
    logic press;
  } kdph_lane_t;

endpackage

// ===== rtl/keypad_debounce_press_to_hid.sv =====
`timescale 1ns / 1ps
// latency: the first press result of a scan is shown the cycle after the scan transfer
// throughput: one press result per cycle while out_ready is high; a scan's presses go out one
//   at a time and a scan with none sends nothing; the next scan transfers with the last result
// all key lanes debounce in parallel in the transfer cycle; the pending press mask sets the rate
// reset (synchronous, active low) clears settled keys, stamps and pending results,
//   and loads active_keys 6 and a lockout of 50 ms

module keypad_debounce_press_to_hid
  import kdph_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [RAW_BITS-1:0]    in_raw_keys,
  input  logic [STAMP_W-1:0]     in_now_ms,
  input  logic                   in_link_up,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KEY_ID_W-1:0]    out_key_id,
  output logic [KEYCODE_W-1:0]   out_hid_keycode,
  output logic                   out_sent,
  output logic [RAW_BITS-1:0]    out_debounced_keys,
  output logic                   out_last
);

  logic [ACTIVE_W-1:0] active_keys_r;
  logic [DEB_W-1:0]    lockout_ms_r;
  logic [NUM_KEYS-1:0] raw_bit;
  logic [NUM_KEYS-1:0] settled_nxt;
  logic [NUM_KEYS-1:0] press_mask;
  logic [RAW_BITS-1:0] keys;
  logic                load;
  kdph_lane_t          lane_st [NUM_KEYS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_keys_r <= ACTIVE_KEYS_RST;
      lockout_ms_r  <= DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ACTIVE_KEYS: active_keys_r <= cfg_wdata[ACTIVE_W-1:0];
        CFG_LOCKOUT_MS:  lockout_ms_r <= cfg_wdata[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  assign load = in_valid && in_ready;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    // keys without a raw bit read as released
    if (k < RAW_BITS) begin : g_raw
      assign raw_bit[k] = in_raw_keys[k];
    end else begin : g_none
      assign raw_bit[k] = 1'b0;
    end

    kdph_lane #(
      .LANE(k)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .load       (load),
      .raw_bit    (raw_bit[k]),
      .now_ms     (in_now_ms),
      .lockout_ms (lockout_ms_r),
      .active_keys(active_keys_r),
      .st         (lane_st[k])
    );

    assign settled_nxt[k] = lane_st[k].settled_nxt;
    assign press_mask[k]  = lane_st[k].press;
  end

  for (genvar j = 0; j < RAW_BITS; j++) begin : g_keys
    if (j < NUM_KEYS) begin : g_have
      assign keys[j] = settled_nxt[j];
    end else begin : g_zero
      assign keys[j] = 1'b0;
    end
  end

  kdph_merge #(
    .NUM_KEYS(NUM_KEYS)
  ) u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .press_mask        (press_mask),
    .keys              (keys),
    .link              (in_link_up),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_key_id        (out_key_id),
    .out_hid_keycode   (out_hid_keycode),
    .out_sent          (out_sent),
    .out_debounced_keys(out_debounced_keys),
    .out_last          (out_last)
  );

endmodule

// ===== rtl/kdph_lane.sv =====
`timescale 1ns / 1ps

module kdph_lane
  import kdph_pkg::*;
#(
  parameter int LANE = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                raw_bit,
  input  logic [STAMP_W-1:0]  now_ms,
  input  logic [DEB_W-1:0]    lockout_ms,
  input  logic [ACTIVE_W-1:0] active_keys,
  output kdph_lane_t          st
);

  logic               settled_r;
  logic               settled_nxt;
  logic [STAMP_W-1:0] stamp_r;
  logic [STAMP_W-1:0] stamp_nxt;
  logic [STAMP_W-1:0] elapsed;
  logic               locked;
  logic               accept;
  logic               mapped;

  // lanes at or above the mapped count are debounced but never report
  assign mapped = (LANE < (1 << ACTIVE_W)) && (ACTIVE_W'(LANE) < active_keys);

  // wraparound elapsed time since the last accepted change
  assign elapsed = now_ms - stamp_r;
  assign locked  = elapsed < STAMP_W'(lockout_ms);
  assign accept  = (raw_bit != settled_r) && !locked;

  assign settled_nxt = accept ? raw_bit : settled_r;
  assign stamp_nxt   = accept ? now_ms : stamp_r;

  assign st.settled_nxt = settled_nxt;
  assign st.press       = accept && raw_bit && mapped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settled_r <= 1'b0;
      stamp_r   <= '0;
    end else if (load) begin
      settled_r <= settled_nxt;
      stamp_r   <= stamp_nxt;
    end
  end

endmodule

// ===== rtl/kdph_merge.sv =====
`timescale 1ns / 1ps

module kdph_merge
  import kdph_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [NUM_KEYS-1:0]    press_mask,
  input  logic [RAW_BITS-1:0]    keys,
  input  logic                   link,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KEY_ID_W-1:0]    out_key_id,
  output logic [KEYCODE_W-1:0]   out_hid_keycode,
  output logic                   out_sent,
  output logic [RAW_BITS-1:0]    out_debounced_keys,
  output logic                   out_last
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [NUM_KEYS-1:0] pend_r;
  logic [NUM_KEYS-1:0] pend_nxt;
  logic [NUM_KEYS-1:0] rest;
  logic [RAW_BITS-1:0] keys_r;
  logic                link_r;
  logic [IDX_W-1:0]    idx;
  logic                load;
  logic                pop;

  // lowest pending press goes out first
  always_comb begin
    idx = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign rest = pend_r & (pend_r - NUM_KEYS'(1));

  assign out_valid          = |pend_r;
  assign out_last           = (rest == '0);
  assign out_key_id         = KEY_ID_W'(idx);
  assign out_hid_keycode    = KEYCODE_BASE + KEYCODE_W'(out_key_id);
  assign out_sent           = link_r;
  assign out_debounced_keys = keys_r;

  assign pop      = out_valid && out_ready;
  assign in_ready = !out_valid || (out_ready && out_last);
  assign load     = in_valid && in_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      pend_nxt = press_mask;
    end else if (pop) begin
      pend_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      keys_r <= keys;
      link_r <= link;
    end
  end

`include "keypad_debounce_press_to_hid_assert.svh"

  `KDPH_ASSERT(a_more_follow, pop && !out_last |=> out_valid, "press results dropped")
  `KDPH_ASSERT(a_scan_reports, load && (press_mask != '0) |=> out_valid, "scan presses lost")
  `KDPH_ASSERT(a_ready_overlap, in_ready && out_valid |-> out_ready && out_last, "scan overrun")
  `KDPH_ASSERT_NEVER(a_id_range, out_valid && (out_key_id >= KEY_ID_W'(RAW_BITS)), "bad key id")

endmodule

// ===== bench/press_result_checker.sv =====
`timescale 1ns / 1ps

module press_result_checker
  import kdph_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [RAW_BITS-1:0]    in_raw_keys,
  input  logic [STAMP_W-1:0]     in_now_ms,
  input  logic                   in_link_up,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [KEY_ID_W-1:0]    out_key_id,
  input  logic [KEYCODE_W-1:0]   out_hid_keycode,
  input  logic                   out_sent,
  input  logic [RAW_BITS-1:0]    out_debounced_keys,
  input  logic                   out_last,
  output int                     mismatches,
  output int                     presses_pending,
  output int                     presses_seen
);

  typedef struct packed {
    logic [KEY_ID_W-1:0]    key_id;
    logic [KEYCODE_W-1:0]   keycode;
    logic                   sent;
    logic [RAW_BITS-1:0]    debounced;
    logic                   last_of_scan;
  } press_result_t;

  press_result_t          press_queue[$];
  logic [RAW_BITS-1:0]    settled;
  logic [STAMP_W-1:0]     stamp[NUM_KEYS_DEF];
  logic [ACTIVE_W-1:0]    mapped_keys;
  logic [DEB_W-1:0]       lockout_ms;

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  // debounce every key of one scan and queue the presses it reports
  function automatic void debounce_scan(logic [RAW_BITS-1:0] raw, logic [STAMP_W-1:0] now,
                                        logic link);
    logic [STAMP_W-1:0]     gap;
    int                     hits[$];
    press_result_t          r;
    for (int i = 0; i < NUM_KEYS_DEF; i++) begin
      gap = now - stamp[i];
      if (raw[i] != settled[i] && gap >= {16'd0, lockout_ms}) begin
        stamp[i] = now;
        settled[i] = raw[i];
        if (raw[i] && i < int'(mapped_keys))
          hits.push_back(i);
      end
    end
    foreach (hits[k]) begin
      r.key_id = KEY_ID_W'(hits[k]);
      r.keycode = KEYCODE_BASE + KEYCODE_W'(hits[k]);
      r.sent = link;
      r.debounced = settled;
      r.last_of_scan = (k == hits.size() - 1);
      press_queue.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    press_result_t want;
    if (!rst_n) begin
      press_queue.delete();
      settled = '0;
      foreach (stamp[i])
        stamp[i] = '0;
      mapped_keys = ACTIVE_KEYS_RST;
      lockout_ms = DEBOUNCE_RST;
    end else begin
      if (out_valid && out_ready) begin
        presses_seen++;
        if (press_queue.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer, expected none actual key %0d code %0d keys %0h",
                   $time, out_key_id, out_hid_keycode, out_debounced_keys);
        end else begin
          want = press_queue.pop_front();
          check_field("key_id", want.key_id, out_key_id);
          check_field("hid_keycode", want.keycode, out_hid_keycode);
          check_field("sent", want.sent, out_sent);
          check_field("debounced_keys", want.debounced, out_debounced_keys);
          check_field("last", want.last_of_scan, out_last);
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ACTIVE_KEYS: mapped_keys = cfg_wdata[ACTIVE_W-1:0];
          CFG_LOCKOUT_MS:  lockout_ms = cfg_wdata[DEB_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        debounce_scan(in_raw_keys, in_now_ms, in_link_up);
    end
    presses_pending = press_queue.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import kdph_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  logic [RAW_BITS-1:0]    in_raw_keys;
  logic [STAMP_W-1:0]     in_now_ms;
  logic                   in_link_up;
  logic                   out_valid;
  logic                   out_ready;
  logic [KEY_ID_W-1:0]    out_key_id;
  logic [KEYCODE_W-1:0]   out_hid_keycode;
  logic                   out_sent;
  logic [RAW_BITS-1:0]    out_debounced_keys;
  logic                   out_last;

  int                     mismatches;
  int                     presses_pending;
  int                     presses_seen;
  int                     scans_sent;
  int                     stall_cycles;
  bit                     no_idle;
  bit                     hold_req;
  logic [STAMP_W-1:0]     cur_ms;
  logic [RAW_BITS-1:0]    prev_raw;
  int                     lockout;

  keypad_debounce_press_to_hid DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raw_keys        (in_raw_keys),
    .in_now_ms          (in_now_ms),
    .in_link_up         (in_link_up),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_key_id         (out_key_id),
    .out_hid_keycode    (out_hid_keycode),
    .out_sent           (out_sent),
    .out_debounced_keys (out_debounced_keys),
    .out_last           (out_last)
  );

  press_result_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raw_keys        (in_raw_keys),
    .in_now_ms          (in_now_ms),
    .in_link_up         (in_link_up),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_key_id         (out_key_id),
    .out_hid_keycode    (out_hid_keycode),
    .out_sent           (out_sent),
    .out_debounced_keys (out_debounced_keys),
    .out_last           (out_last),
    .mismatches         (mismatches),
    .presses_pending    (presses_pending),
    .presses_seen       (presses_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= rst_n && (no_idle || $urandom_range(99) >= 17);
      end
    end
  end

  task automatic send_scan(logic [RAW_BITS-1:0] raw, logic [STAMP_W-1:0] now, logic link);
    if (!no_idle && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_raw_keys <= raw;
    in_now_ms <= now;
    in_link_up <= link;
    do @(posedge clk); while (!in_ready);
    scans_sent++;
    cur_ms = now;
    prev_raw = raw;
    @(negedge clk);
  endtask

  // drain every outstanding press, then let a silent scan finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (presses_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LOCKOUT_MS)
      lockout = int'(data);
    @(negedge clk);
  endtask

  task automatic random_scan();
    logic [RAW_BITS-1:0] raw;
    logic [STAMP_W-1:0]  now;
    int                  pick;
    pick = $urandom_range(99);
    raw = prev_raw;
    now = cur_ms;
    if (pick < 8) begin
      raw = RAW_BITS'($urandom);
      now = $urandom;
    end else begin
      if (pick < 13)
        now = 32'hFFFF_FFFF - $urandom_range(0, 2 * lockout + 2);
      repeat ($urandom_range(0, 3)) raw[$urandom_range(0, RAW_BITS - 1)] ^= 1'b1;
      now += $urandom_range(0, 2 * lockout + 2);
    end
    send_scan(raw, now, $urandom_range(99) < 80);
  endtask

  initial begin
    logic [ACTIVE_W-1:0] mapped;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ACTIVE_KEYS;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_raw_keys = '0;
    in_now_ms = '0;
    in_link_up = 1'b0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    scans_sent = 0;
    cur_ms = '0;
    prev_raw = '0;
    lockout = int'(DEBOUNCE_RST);
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // stamps start at zero, so early changes are locked out
    send_scan(6'h3F, 32'd10, 1'b1);
    send_scan(6'h3F, 32'd50, 1'b1);
    send_scan(6'h00, 32'd60, 1'b0);
    send_scan(6'h00, 32'd100, 1'b0);
    // lockout across the wrap of the millisecond counter
    send_scan(6'h15, 32'hFFFF_FFFF, 1'b0);
    send_scan(6'h00, 32'h0000_0010, 1'b1);
    send_scan(6'h2A, 32'h0000_0010, 1'b1);
    send_scan(6'h2A, 32'h0000_0040, 1'b1);
    // no mapped keys, zero lockout
    wait_idle();
    write_cfg(CFG_ACTIVE_KEYS, 16'd0);
    write_cfg(CFG_LOCKOUT_MS, 16'd0);
    send_scan(6'h3F, 32'h0000_0040, 1'b1);
    send_scan(6'h00, 32'h0000_0040, 1'b0);
    wait_idle();
    write_cfg(CFG_ACTIVE_KEYS, 16'd3);
    send_scan(6'h3F, 32'h0000_0040, 1'b1);
    send_scan(6'h00, 32'h0000_0040, 1'b1);
    // widest lockout, all data bits set on the key count
    wait_idle();
    write_cfg(CFG_ACTIVE_KEYS, 16'hFFFF);
    write_cfg(CFG_LOCKOUT_MS, 16'hFFFF);
    send_scan(6'h3F, 32'h0000_0040 + 32'd65534, 1'b1);
    send_scan(6'h3F, 32'h0000_0040 + 32'd65535, 1'b1);
    send_scan(6'h01, 32'h0000_0040 + 32'd65535, 1'b0);
    send_scan(6'h00, 32'h0000_0040 + 32'd131070, 1'b1);
    wait_idle();
    write_cfg(CFG_ACTIVE_KEYS, 16'hA5A5);
    write_cfg(CFG_LOCKOUT_MS, 16'd1);
    send_scan(6'h3F, cur_ms + 32'd1, 1'b1);
    send_scan(6'h20, cur_ms, 1'b1);
    send_scan(6'h20, cur_ms + 32'd1, 1'b0);

    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_cfg(CFG_ACTIVE_KEYS, 16'(ACTIVE_KEYS_RST));
          write_cfg(CFG_LOCKOUT_MS, DEBOUNCE_RST);
        end
        1: begin
          mapped = ACTIVE_W'($urandom_range(1, 7));
          write_cfg(CFG_ACTIVE_KEYS, 16'(mapped));
          write_cfg(CFG_LOCKOUT_MS, 16'd0);
        end
        2: begin
          write_cfg(CFG_ACTIVE_KEYS, 16'd7);
          write_cfg(CFG_LOCKOUT_MS, 16'hFFFF);
        end
        3: begin
          write_cfg(CFG_ACTIVE_KEYS, 16'($urandom));
          write_cfg(CFG_LOCKOUT_MS, 16'($urandom));
        end
        default: begin
          write_cfg(CFG_ACTIVE_KEYS, 16'(ACTIVE_KEYS_RST));
          write_cfg(CFG_LOCKOUT_MS, 16'($urandom_range(1, 20)));
        end
      endcase
      no_idle = (phase == 2);
      for (int n = 0; n < 100; n++) begin
        if (phase == 1 && n == 40)
          hold_req = 1'b1;
        random_scan();
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (presses_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("covered %0d scans and %0d press transfers, lockout 0 to 65535 ms,", scans_sent,
             presses_seen);
    $display("mapped keys 0 to 7, timestamp wrap and a long result-side hold-off");
    if (mismatches == 0 && presses_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
